[src/vtge_pkg.sv]
// Shared types and constants for the vector tile geometry encoder.
package vtge_pkg;

  localparam int MAX_VERTICES_DEF = 32;

  localparam logic [1:0] KIND_POINT    = 2'd0;
  localparam logic [1:0] KIND_LINE     = 2'd1;
  localparam logic [1:0] KIND_EXTERIOR = 2'd2;
  localparam logic [1:0] KIND_INTERIOR = 2'd3;

  localparam logic [1:0] WORD_COMMAND = 2'd0;
  localparam logic [1:0] WORD_PAIR    = 2'd1;
  localparam logic [1:0] WORD_ERROR   = 2'd2;

  localparam logic [2:0] CMD_MOVE_TO = 3'd1;
  localparam logic [2:0] CMD_LINE_TO = 3'd2;
  localparam logic [2:0] CMD_CLOSE   = 3'd7;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_WIDE     = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         part_kind;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic               last_of_part;
    logic               first_of_geometry;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  word_kind;
    logic [31:0] command_word;
    logic [31:0] param_x;
    logic [31:0] param_y;
    logic [1:0]  error_code;
    logic        last_word;
  } out_word_t;

endpackage

[src/vector_tile_geometry_encoder_unit.sv]
// Top level of the vector tile geometry encoder.
// Vertices enter one per cycle (start high, busy low) and are buffered in a
// vertex memory until the part ends; a point is encoded at once. When a part
// ends the block goes busy: it checks overflow and the closing vertex, walks
// the ring once through the memory for the exact shoelace sign (a read, two
// products and an accumulate per vertex, one 32x32 multiplier per step), then
// reads the memory once more to emit MoveTo, the first pair, LineTo, the other
// pairs and, for a ring, ClosePath, one word per cycle. Busy first closes out
// the part (overflowed, skipped and degenerate parts end there); a ring then
// makes the area pass and emission; a line goes on to emission (MoveTo, LineTo,
// n pairs); a point emits MoveTo and its pair. n counts the vertices left after
// duplicate and closing-vertex removal. Each result word is on result for
// exactly one cycle with strobe high; the receiver has no way to hold results
// off, so it must take every word as it appears.
module vector_tile_geometry_encoder_unit
  import vtge_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  vertex,
  output logic      busy,
  output logic      strobe,
  output out_word_t result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIN   = 4'd1;
  localparam logic [3:0] S_PTM   = 4'd2;
  localparam logic [3:0] S_PTP   = 4'd3;
  localparam logic [3:0] S_ARD   = 4'd4;
  localparam logic [3:0] S_ARP   = 4'd5;
  localparam logic [3:0] S_ARQ   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_ADN   = 4'd8;
  localparam logic [3:0] S_MOVE  = 4'd9;
  localparam logic [3:0] S_PAIR  = 4'd10;
  localparam logic [3:0] S_LINE  = 4'd11;
  localparam logic [3:0] S_CLOSE = 4'd12;

  // vertex memory, one write and one registered read per cycle
  logic signed [31:0] mem_x [MAX_VERTICES];
  logic signed [31:0] mem_y [MAX_VERTICES];
  logic signed [31:0] rd_x, rd_y;
  logic [AW-1:0]      rd_addr;

  logic [3:0]         state;
  logic [CW-1:0]      count;     // vertices buffered in this part
  logic [CW-1:0]      n;         // vertices to encode
  logic [CW-1:0]      idx;       // area walk index / pair index
  logic               ovf;
  logic               skip;
  logic               rev;
  logic [1:0]         kind;
  logic signed [31:0] cur_x, cur_y;     // cursor
  logic signed [31:0] first_x, first_y; // entry 0
  logic signed [31:0] last_x, last_y;   // newest entry
  logic signed [31:0] pt_x, pt_y;       // point vertex
  logic signed [31:0] prev_x, prev_y, vx, vy;
  logic signed [63:0] prod_p, prod_q;
  logic signed [71:0] area;

  logic accept;
  logic dup;
  logic ring, ext, close_dup;
  logic [CW-1:0] n_eff;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign dup    = (count != '0) && (last_x == vertex.x_coord) && (last_y == vertex.y_coord);
  assign ring   = kind[1];
  assign ext    = (kind == KIND_EXTERIOR);
  assign close_dup = ring && (count >= CW'(2)) && (first_x == last_x) && (first_y == last_y);
  assign n_eff  = close_dup ? count - CW'(1) : count;

  // emission order follows rev
  function automatic logic [AW-1:0] em_addr(input logic [CW-1:0] i, input logic [CW-1:0] nn,
                                            input logic r);
    logic [CW-1:0] a;
    a = r ? nn - CW'(1) - i : i;
    return a[AW-1:0];
  endfunction

  always_comb begin
    unique case (state)
      S_ARD:   rd_addr = idx[AW-1:0];
      S_MOVE:  rd_addr = em_addr('0, n, rev);
      S_PAIR:  rd_addr = em_addr(idx + CW'(1), n, rev);
      S_LINE:  rd_addr = em_addr(CW'(1), n, rev);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && vertex.part_kind != KIND_POINT && !dup && count < CW'(MAX_VERTICES)) begin
      mem_x[count[AW-1:0]] <= vertex.x_coord;
      mem_y[count[AW-1:0]] <= vertex.y_coord;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // delta pair against the cursor
  logic signed [31:0] src_x, src_y;
  logic [32:0]        dx, dy;
  logic               wide;
  assign src_x = (state == S_PTP) ? pt_x : rd_x;
  assign src_y = (state == S_PTP) ? pt_y : rd_y;
  assign dx    = {src_x[31], src_x} - {cur_x[31], cur_x};
  assign dy    = {src_y[31], src_y} - {cur_y[31], cur_y};
  assign wide  = (dx[32] != dx[31]) || (dy[32] != dy[31]);

  out_word_t res;
  logic      res_valid;

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    unique case (state)
      S_FIN: begin
        if (!(kind == KIND_INTERIOR && skip) && ovf) begin
          res_valid      = 1'b1;
          res.word_kind  = WORD_ERROR;
          res.error_code = ERR_OVERFLOW;
          res.last_word  = 1'b1;
        end
      end
      S_PTM, S_MOVE: begin
        res_valid        = 1'b1;
        res.word_kind    = WORD_COMMAND;
        res.command_word = {29'd1, CMD_MOVE_TO};
      end
      S_LINE: begin
        res_valid        = 1'b1;
        res.word_kind    = WORD_COMMAND;
        res.command_word = {29'(n - CW'(1)), CMD_LINE_TO};
      end
      S_CLOSE: begin
        res_valid        = 1'b1;
        res.word_kind    = WORD_COMMAND;
        res.command_word = {29'd1, CMD_CLOSE};
        res.last_word    = 1'b1;
      end
      S_PTP, S_PAIR: begin
        res_valid = 1'b1;
        if (wide) begin
          res.word_kind  = WORD_ERROR;
          res.error_code = ERR_WIDE;
        end else begin
          res.word_kind = WORD_PAIR;
          res.param_x   = {dx[30:0], 1'b0} ^ {32{dx[32]}};
          res.param_y   = {dy[30:0], 1'b0} ^ {32{dy[32]}};
        end
        res.last_word = (state == S_PTP) || (!ring && idx == n - CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    result <= res;
    if (rst) strobe <= 1'b0;
    else     strobe <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      skip  <= 1'b0;
      cur_x <= '0;
      cur_y <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind <= vertex.part_kind;
            if (vertex.first_of_geometry) begin
              cur_x <= '0;
              cur_y <= '0;
              skip  <= 1'b0;
            end
            if (vertex.part_kind == KIND_POINT) begin
              count <= '0;
              ovf   <= 1'b0;
              pt_x  <= vertex.x_coord;
              pt_y  <= vertex.y_coord;
              state <= S_PTM;
            end else begin
              if (!dup) begin
                if (count < CW'(MAX_VERTICES)) begin
                  count  <= count + CW'(1);
                  last_x <= vertex.x_coord;
                  last_y <= vertex.y_coord;
                  if (count == '0) begin
                    first_x <= vertex.x_coord;
                    first_y <= vertex.y_coord;
                  end
                end else begin
                  ovf <= 1'b1;
                end
              end
              if (vertex.last_of_part) state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          count <= '0;
          ovf   <= 1'b0;
          n     <= n_eff;
          rev   <= 1'b0;
          idx   <= CW'(1);
          area  <= '0;
          prev_x <= first_x;
          prev_y <= first_y;
          if (kind == KIND_INTERIOR && skip) begin
            state <= S_IDLE;
          end else if (ovf) begin
            if (ext) skip <= 1'b1;
            state <= S_IDLE;
          end else if (n_eff < (ring ? CW'(3) : CW'(2))) begin
            if (ext) skip <= 1'b1;
            state <= S_IDLE;
          end else if (ring) begin
            state <= S_ARD;
          end else begin
            state <= S_MOVE;
          end
        end
        S_ARD: state <= S_ARP;
        S_ARP: begin
          // closing edge wraps back to entry 0
          vx     <= (idx == n) ? first_x : rd_x;
          vy     <= (idx == n) ? first_y : rd_y;
          prod_p <= prev_x * ((idx == n) ? first_y : rd_y);
          state  <= S_ARQ;
        end
        S_ARQ: begin
          prod_q <= vx * prev_y;
          state  <= S_ACC;
        end
        S_ACC: begin
          area   <= area + 72'(prod_p) - 72'(prod_q);
          prev_x <= vx;
          prev_y <= vy;
          if (idx == n) begin
            state <= S_ADN;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_ARD;
          end
        end
        S_ADN: begin
          if (area == '0) begin
            if (ext) skip <= 1'b1;
            state <= S_IDLE;
          end else begin
            rev <= (!area[71]) != ext;
            if (ext) skip <= 1'b0;
            state <= S_MOVE;
          end
        end
        S_PTM: state <= S_PTP;
        S_PTP: begin
          cur_x <= pt_x;
          cur_y <= pt_y;
          state <= S_IDLE;
        end
        S_MOVE: begin
          idx   <= '0;
          state <= S_PAIR;
        end
        S_PAIR: begin
          cur_x <= rd_x;
          cur_y <= rd_y;
          if (idx == '0) begin
            state <= S_LINE;
          end else if (idx == n - CW'(1)) begin
            state <= ring ? S_CLOSE : S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_LINE: begin
          idx   <= CW'(1);
          state <= S_PAIR;
        end
        S_CLOSE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/vtge_checker.sv]
// Port-level checks for the geometry encoder, bound to the top level.
module vtge_checker
  import vtge_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input in_word_t  vertex,
  input logic      busy,
  input logic      strobe,
  input out_word_t result
);

  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && vertex.part_kind == KIND_POINT) |=> busy)
    else $error("point did not raise busy");

  a_pair_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.word_kind == WORD_PAIR) |->
      (result.error_code == ERR_NONE && result.command_word == 32'd0))
    else $error("pair word carries stray fields");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.word_kind == WORD_ERROR) |->
      (result.error_code != ERR_NONE && result.param_x == 32'd0 && result.param_y == 32'd0))
    else $error("error word malformed");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (result.word_kind == WORD_COMMAND || result.word_kind == WORD_PAIR ||
                result.word_kind == WORD_ERROR))
    else $error("illegal word kind");

endmodule

bind vector_tile_geometry_encoder_unit vtge_checker u_vtge_checker (
  .clk(clk), .rst(rst), .start(start), .vertex(vertex),
  .busy(busy), .strobe(strobe), .result(result)
);

[tb/tb_top.sv]
// Self-checking testbench for the vector tile geometry encoder top level.
`timescale 1ns / 100ps

module tb_top;
  import vtge_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic      clk;
  logic      rst;
  logic      start;
  in_word_t  vertex;
  logic      busy;
  logic      strobe;
  out_word_t result;

  vector_tile_geometry_encoder_unit DUT (
    .clk(clk), .rst(rst), .start(start), .vertex(vertex),
    .busy(busy), .strobe(strobe), .result(result)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: private copy of the encoder's buffer, cursor and flags.
  // ---------------------------------------------------------------------------
  logic signed [31:0] buf_x [MAXV];
  logic signed [31:0] buf_y [MAXV];
  int                 buf_count;
  logic signed [31:0] pen_x, pen_y;
  bit                 holes_skipped;
  bit                 buf_overflow;

  out_word_t expected_words[$];
  int        mismatches;
  int        idle_cycles;
  int        send_idle_pct;
  bit        failed;

  function automatic out_word_t cmd(logic [2:0] id, int unsigned count);
    out_word_t w;
    w = '0;
    w.word_kind = WORD_COMMAND;
    w.command_word = {count[28:0], id};
    return w;
  endfunction

  function automatic logic [31:0] zz(logic signed [63:0] d);
    return {d[30:0], 1'b0} ^ {32{d[63]}};
  endfunction

  // Append one word to the expected stream.
  task automatic add_expected(out_word_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  // Delta from the cursor; wide deltas become an error word, cursor moves anyway.
  function automatic out_word_t delta_word(logic signed [31:0] x, logic signed [31:0] y);
    out_word_t          w;
    logic signed [63:0] dx, dy;
    w = '0;
    dx = 64'(x) - 64'(pen_x);
    dy = 64'(y) - 64'(pen_y);
    if (dx < -64'sd2147483648 || dx > 64'sd2147483647 ||
        dy < -64'sd2147483648 || dy > 64'sd2147483647) begin
      w.word_kind = WORD_ERROR;
      w.error_code = ERR_WIDE;
    end else begin
      w.word_kind = WORD_PAIR;
      w.param_x = zz(dx);
      w.param_y = zz(dy);
    end
    pen_x = x;
    pen_y = y;
    return w;
  endfunction

  // Exact sign of doubled shoelace area (128-bit accumulation is ample).
  function automatic int ring_area_sign(int n);
    logic signed [127:0] acc;
    int j;
    acc = '0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      acc += 128'(buf_x[i]) * 128'(buf_y[j]) - 128'(buf_x[j]) * 128'(buf_y[i]);
    end
    if (acc < 0) return -1;
    if (acc == 0) return 0;
    return 1;
  endfunction

  // Queue up the words one vertex is expected to produce.
  task automatic predict_vertex(in_word_t v);
    out_word_t w;
    int        n, sgn, j, base;
    bit        ring, ext, ovf, rev;
    if (v.first_of_geometry) begin
      pen_x = 0; pen_y = 0; holes_skipped = 0;
    end
    if (v.part_kind == KIND_POINT) begin
      buf_count = 0;
      buf_overflow = 0;
      add_expected(cmd(CMD_MOVE_TO, 1));
      w = delta_word(v.x_coord, v.y_coord);
      w.last_word = 1'b1;
      add_expected(w);
      return;
    end
    if (buf_count > 0 && buf_x[buf_count-1] == v.x_coord && buf_y[buf_count-1] == v.y_coord)
      ; // repeated vertex, dropped
    else if (buf_count < MAXV) begin
      buf_x[buf_count] = v.x_coord;
      buf_y[buf_count] = v.y_coord;
      buf_count++;
    end else
      buf_overflow = 1;
    if (!v.last_of_part) return;
    n = buf_count;
    ovf = buf_overflow;
    buf_count = 0;
    buf_overflow = 0;
    ring = v.part_kind >= KIND_EXTERIOR;
    ext = v.part_kind == KIND_EXTERIOR;
    if (v.part_kind == KIND_INTERIOR && holes_skipped) return;
    if (ovf) begin
      if (ext) holes_skipped = 1;
      w = '0;
      w.word_kind = WORD_ERROR;
      w.error_code = ERR_OVERFLOW;
      w.last_word = 1'b1;
      add_expected(w);
      return;
    end
    if (ring && n >= 2 && buf_x[0] == buf_x[n-1] && buf_y[0] == buf_y[n-1]) n--;
    if (n < (ring ? 3 : 2)) begin
      if (ext) holes_skipped = 1;
      return;
    end
    rev = 0;
    if (ring) begin
      sgn = ring_area_sign(n);
      if (sgn == 0) begin
        if (ext) holes_skipped = 1;
        return;
      end
      rev = (sgn > 0) != ext;
      if (ext) holes_skipped = 0;
    end
    base = expected_words.size();
    add_expected(cmd(CMD_MOVE_TO, 1));
    for (int i = 0; i < n; i++) begin
      j = rev ? n - 1 - i : i;
      if (i == 1) add_expected(cmd(CMD_LINE_TO, n - 1));
      add_expected(delta_word(buf_x[j], buf_y[j]));
    end
    if (ring) add_expected(cmd(CMD_CLOSE, 1));
    expected_words[expected_words.size()-1].last_word = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Word sender: random gaps, holds start until the block takes the word.
  // start stays high after a take so the next word can follow back to back.
  // ---------------------------------------------------------------------------
  task automatic send_vertex(logic [1:0] kind, logic signed [31:0] x,
                             logic signed [31:0] y, bit last, bit first);
    in_word_t v;
    v.part_kind = kind;
    v.x_coord = x;
    v.y_coord = y;
    v.last_of_part = last;
    v.first_of_geometry = first;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_vertex(v);
  endtask

  // Result checker: every strobe cycle is one word, compared in order.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", result);
      end else if (result !== expected_words[0]) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: expected %h got %h", expected_words[0], result);
        void'(expected_words.pop_front());
      end else
        void'(expected_words.pop_front());
    end
  end

  // Watchdog: counts cycles where neither a vertex nor a word is taken.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 4096)));
      2: return $signed(32'($urandom_range(0, 8)) - 32'sd4);
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // Send one part of the given kind with n vertices from a small pattern.
  task automatic send_part(logic [1:0] kind, int n, bit first, bit closed);
    logic signed [31:0] x0, y0, xs, ys;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(9) == 0) begin
        xs = rnd_coord(); ys = rnd_coord();
      end else if ($urandom_range(7) != 0) begin
        xs = xs + $signed(32'($urandom_range(0, 40)) - 32'sd20);
        ys = ys + $signed(32'($urandom_range(0, 40)) - 32'sd20);
      end
      if (i == 0) begin x0 = xs; y0 = ys; end
      if (closed && i == n - 1 && n > 1) begin xs = x0; ys = y0; end
      send_vertex(kind, xs, ys, i == n - 1, first && i == 0);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Directed: points at the corners, wide deltas, line/ring edge cases.
  task automatic test_directed();
    send_vertex(KIND_POINT, 32'sh7fffffff, 32'sh80000000, 0, 1);
    send_vertex(KIND_POINT, 32'sh80000000, 32'sh7fffffff, 1, 0); // wide delta
    send_vertex(KIND_LINE, 5, 5, 0, 1);
    send_vertex(KIND_LINE, 5, 5, 1, 0);                          // degenerate line
    send_vertex(KIND_LINE, -1, 2, 0, 0);
    send_vertex(KIND_LINE, 3, -4, 1, 0);
    // exterior ring, counterclockwise in y-down: reversed
    send_vertex(KIND_EXTERIOR, 0, 0, 0, 1);
    send_vertex(KIND_EXTERIOR, 0, 10, 0, 0);
    send_vertex(KIND_EXTERIOR, 10, 10, 0, 0);
    send_vertex(KIND_EXTERIOR, 0, 0, 1, 0);
    send_vertex(KIND_INTERIOR, 2, 2, 0, 0);
    send_vertex(KIND_INTERIOR, 4, 2, 0, 0);
    send_vertex(KIND_INTERIOR, 2, 4, 1, 0);
    // zero-area exterior, then a hole that must be skipped
    send_vertex(KIND_EXTERIOR, 0, 0, 0, 1);
    send_vertex(KIND_EXTERIOR, 1, 1, 0, 0);
    send_vertex(KIND_EXTERIOR, 2, 2, 1, 0);
    send_vertex(KIND_INTERIOR, 0, 0, 0, 0);
    send_vertex(KIND_INTERIOR, 5, 0, 0, 0);
    send_vertex(KIND_INTERIOR, 0, 5, 1, 0);
    // orphan hole, then a point cutting off an unfinished line
    send_vertex(KIND_INTERIOR, 0, 0, 0, 1);
    send_vertex(KIND_INTERIOR, 0, 7, 0, 0);
    send_vertex(KIND_INTERIOR, 7, 0, 1, 0);
    send_vertex(KIND_LINE, 9, 9, 0, 0);
    send_vertex(KIND_POINT, 0, 0, 0, 0);
    drain_results();
  endtask

  // Overflow: an exterior ring past the buffer, then its hole is skipped.
  task automatic test_overflow();
    for (int i = 0; i <= MAXV; i++)
      send_vertex(KIND_EXTERIOR, i, i * i, i == MAXV, i == 0);
    send_part(KIND_INTERIOR, 4, 0, 1);
    for (int i = 0; i < MAXV; i++)                              // exactly full line
      send_vertex(KIND_LINE, -i, i, i == MAXV - 1, i == 0);
    for (int i = 0; i <= MAXV + 2; i++)
      send_vertex(KIND_LINE, i, -i, i == MAXV + 2, 0);
    drain_results();
  endtask

  // Random geometries, mostly well-formed parts with random content.
  task automatic test_random(int items);
    int sent, n, k;
    bit first;
    sent = 0;
    while (sent < items) begin
      first = $urandom_range(3) == 0;
      k = $urandom_range(9);
      n = (k == 9) ? $urandom_range(MAXV - 2, MAXV + 3) : $urandom_range(1, 7);
      case ($urandom_range(4))
        0: begin send_vertex(KIND_POINT, rnd_coord(), rnd_coord(),
                             $urandom_range(1), first); n = 1; end
        1: send_part(KIND_LINE, n, first, 0);
        2: send_part(KIND_EXTERIOR, n, first, $urandom_range(1));
        3: send_part(KIND_INTERIOR, n, first, $urandom_range(1));
        default: send_part(2'($urandom_range(1, 3)), n, first, 0);
      endcase
      sent += n;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    vertex = '0;
    buf_count = 0;
    pen_x = 0; pen_y = 0;
    holes_skipped = 0;
    buf_overflow = 0;
    mismatches = 0;
    idle_cycles = 0;
    failed = 0;
    send_idle_pct = 28;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random(55);
    send_idle_pct = 58;
    test_random(50);
    send_idle_pct = 0;
    test_random(50);
    drain_results();

    if (!failed && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/vtge_pkg.sv
src/vector_tile_geometry_encoder_unit.sv
src/vtge_checker.sv
tb/tb_top.sv
